### rtl/core/held_note_table_core_macros.svh
// Assertion macros for the held note table checker.
`ifndef HELD_NOTE_TABLE_CORE_MACROS_SVH
`define HELD_NOTE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HNT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define HNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### rtl/core/hnt_pkg.sv
// Shared constants, types and a helper function of the held note table.
`default_nettype none

package hnt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ACTION_W = 2;
    localparam int CHAN_W   = 4;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int TICK_W   = 32;
    localparam int PERIOD_W = 32;
    localparam int FRAME_W  = 48;
    localparam int POS_W    = 5;
    localparam int TCOUNT_W = 6;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd68267;

    // frame = floor(period * ticks * 441 / (5 * 2^17)) mod 2^48
    localparam int PROD_W     = PERIOD_W + TICK_W;
    localparam int MUL_W      = 9;
    localparam logic [MUL_W-1:0] SAMPLE_MUL = 9'd441;
    localparam int SCALED_W   = PROD_W + MUL_W;
    localparam int DIV_SHIFT  = 17;
    localparam int NUM_W      = SCALED_W - DIV_SHIFT;
    localparam int DIGIT_W    = 4;
    localparam int DIV_DIGITS = NUM_W / DIGIT_W;
    localparam int DCNT_W     = $clog2(DIV_DIGITS);
    localparam int REM_W      = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NOTE_ON  = 2'd0,
        ACT_NOTE_OFF = 2'd1,
        ACT_OTHER    = 2'd2
    } t_action;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } t_entry;

    typedef struct packed {
        logic signed [FRAME_W-1:0] frames_elapsed;
        logic                      entry_valid;
        logic [POS_W-1:0]          entry_position;
        logic [CHAN_W-1:0]         entry_channel;
        logic [NOTE_W-1:0]         entry_note;
        logic [VEL_W-1:0]          entry_velocity;
        logic [TCOUNT_W-1:0]       table_count;
        logic                      overflow;
        logic                      last;
    } t_result;

    typedef struct packed {
        logic [DIGIT_W-1:0] quo;
        logic [REM_W-1:0]   rem;
    } t_div5;

    // One radix-16 digit of a divide by five; t < 80, reciprocal 205/1024 is exact here.
    function automatic t_div5 div5_step(input logic [REM_W-1:0] rem,
                                        input logic [DIGIT_W-1:0] digit);
        logic [REM_W+DIGIT_W-1:0] t;
        logic [14:0]              scaled;
        logic [REM_W+DIGIT_W-1:0] back;
        t_div5                    res;
        t        = {rem, digit};
        scaled   = 15'(t) * 15'd205;
        res.quo  = scaled[13:10];
        back     = 7'(res.quo) * 7'd5;
        res.rem  = REM_W'(t - back);
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/hnt_event_if.sv
// Event input channel: valid/ready handshake with the event fields.
`default_nettype none

interface hnt_event_if;
    logic                          valid;
    logic                          ready;
    logic [hnt_pkg::ACTION_W-1:0]  action;
    logic [hnt_pkg::CHAN_W-1:0]    midi_channel;
    logic [hnt_pkg::NOTE_W-1:0]    note_number;
    logic [hnt_pkg::VEL_W-1:0]     note_velocity;
    logic [hnt_pkg::TICK_W-1:0]    tick_count;

    modport source(output valid, action, midi_channel, note_number, note_velocity,
                   tick_count, input ready);
    modport sink(input valid, action, midi_channel, note_number, note_velocity,
                 tick_count, output ready);
endinterface

`default_nettype wire

### rtl/core/hnt_result_if.sv
// Result output channel: valid/ready handshake with the result fields.
`default_nettype none

interface hnt_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [hnt_pkg::FRAME_W-1:0]  frames_elapsed;
    logic                                entry_valid;
    logic [hnt_pkg::POS_W-1:0]           entry_position;
    logic [hnt_pkg::CHAN_W-1:0]          entry_channel;
    logic [hnt_pkg::NOTE_W-1:0]          entry_note;
    logic [hnt_pkg::VEL_W-1:0]           entry_velocity;
    logic [hnt_pkg::TCOUNT_W-1:0]        table_count;
    logic                                overflow;
    logic                                last;

    modport source(output valid, frames_elapsed, entry_valid, entry_position,
                   entry_channel, entry_note, entry_velocity, table_count, overflow,
                   last, input ready);
    modport sink(input valid, frames_elapsed, entry_valid, entry_position,
                 entry_channel, entry_note, entry_velocity, table_count, overflow,
                 last, output ready);
endinterface

`default_nettype wire

### rtl/core/held_note_table_core.sv
// Held note table: ordered note memory, note on/off handling, tick to frame tracker.
//
// Usage:
//   i_event  : one word per MIDI event (action, channel, note, velocity, tick_count).
//              Taken only while the core is idle; ready drops for the whole event.
//   o_result : one word per held note after the event, in table order, or a single
//              word with entry_valid low when the table is empty; last marks the end.
//              Every word repeats frames_elapsed, table_count and overflow.
//   i_cfg_wr_en / i_cfg_wr_data : write of the Q16.16 ms-per-tick register. Write
//              only while no event is in flight.
// Per event:
//   frame math runs beside the table work: 32x32 product at accept, x441 scale,
//   14 radix-16 divide-by-five steps, delta.
//   note on / other: first word once the delta is ready.
//   note off: in-place compaction through the table's write port and registered
//   read port, overlapped with the frame math; first word once both are done.
//   Readout streams one word per cycle while the receiver does not stall.
// Reset clears the count, the frame position and the register to 68267; the table
// memory itself is not cleared. A stalled receiver holds the output register and
// backs the readout up; the next event can be taken while the last word still waits.
`default_nettype none

module held_note_table_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [hnt_pkg::PERIOD_W-1:0]  i_cfg_wr_data,
    hnt_event_if.sink                          i_event,
    hnt_result_if.source                       o_result
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_COMPACT = 4'b0010,
        ST_SYNC    = 4'b0100,
        ST_READ    = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        FR_IDLE  = 4'b0001,
        FR_SCALE = 4'b0010,
        FR_DIV   = 4'b0100,
        FR_DELTA = 4'b1000
    } t_fr_state;

    localparam int AW = hnt_pkg::ADDR_W;
    localparam int CW = hnt_pkg::CNT_W;

    // control state
    t_state                          r_state, n_state;
    t_fr_state                       r_fr_state;
    logic [hnt_pkg::PERIOD_W-1:0]    r_period;
    logic [CW-1:0]                   r_count;
    logic [hnt_pkg::FRAME_W-1:0]     r_last_pos;
    logic                            r_out_valid;
    logic                            r_rd_pend;
    logic [CW-1:0]                   r_rd_idx;
    logic [CW-1:0]                   r_wr_idx;

    // datapath
    logic [hnt_pkg::FRAME_W-1:0]     r_delta;
    logic                            r_ovf;
    logic [hnt_pkg::CHAN_W-1:0]      r_chan;
    logic [hnt_pkg::NOTE_W-1:0]      r_note;
    logic [CW-1:0]                   r_q_pos;
    hnt_pkg::t_entry                 r_mem [hnt_pkg::TABLE_DEPTH];
    hnt_pkg::t_entry                 r_ram_q;
    hnt_pkg::t_result                r_out;
    logic [hnt_pkg::PROD_W-1:0]      r_fr_prod;
    logic [hnt_pkg::NUM_W-1:0]       r_div_num;
    logic [hnt_pkg::FRAME_W-1:0]     r_div_quo;
    logic [hnt_pkg::REM_W-1:0]       r_div_rem;
    logic [hnt_pkg::DCNT_W-1:0]      r_div_cnt;

    logic                            accept;
    logic                            is_on, is_off, room;
    logic                            rd_more, keep, move, out_free, empty_load;
    logic                            mem_we, mem_re;
    logic [AW-1:0]                   mem_waddr, mem_raddr;
    hnt_pkg::t_entry                 mem_wdata, ev_entry;
    logic [hnt_pkg::PROD_W-1:0]      prod_c;
    logic [hnt_pkg::SCALED_W-1:0]    scaled_c;
    hnt_pkg::t_div5                  dstep;

    assign accept   = i_event.valid && i_event.ready;
    assign is_on    = (i_event.action == hnt_pkg::ACT_NOTE_ON);
    assign is_off   = (i_event.action == hnt_pkg::ACT_NOTE_OFF);
    assign room     = (r_count < CW'(hnt_pkg::TABLE_DEPTH));
    assign rd_more  = (r_rd_idx < r_count);
    assign out_free = !r_out_valid || o_result.ready;
    assign move     = (r_state == ST_READ) && r_rd_pend && out_free;
    assign empty_load = (r_state == ST_READ) && (r_count == '0) && out_free;
    assign keep     = r_rd_pend &&
                      !((r_ram_q.note == r_note) && (r_ram_q.chan == r_chan));

    assign ev_entry.chan = i_event.midi_channel;
    assign ev_entry.note = i_event.note_number;
    assign ev_entry.vel  = i_event.note_velocity;

    assign i_event.ready = (r_state == ST_IDLE);

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = ev_entry;
        mem_re    = 1'b0;
        mem_raddr = r_rd_idx[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                mem_we = accept && is_on && room;
            end
            ST_COMPACT: begin
                mem_re    = rd_more;
                mem_we    = keep;
                mem_waddr = r_wr_idx[AW-1:0];
                mem_wdata = r_ram_q;
            end
            ST_READ: begin
                mem_re = rd_more && (!r_rd_pend || move);
            end
            default: begin
            end
        endcase
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_ram_q <= r_mem[mem_raddr];
        end
    end

    // event sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = is_off ? ST_COMPACT : ST_SYNC;
                end
            end
            ST_COMPACT: begin
                if (!rd_more && !r_rd_pend) begin
                    n_state = ST_SYNC;
                end
            end
            ST_SYNC: begin
                if (r_fr_state == FR_IDLE) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (empty_load || (move && ((r_q_pos + CW'(1)) == r_count))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_period    <= hnt_pkg::PERIOD_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            if (accept && is_on && room) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == ST_COMPACT && !rd_more && !r_rd_pend) begin
                r_count <= r_wr_idx;
            end

            // read pointer and pending flag shared by compaction and readout
            if (accept || r_state == ST_SYNC) begin
                r_rd_idx  <= '0;
                r_wr_idx  <= '0;
                r_rd_pend <= 1'b0;
            end else begin
                if (mem_re) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
                if (r_state == ST_COMPACT) begin
                    r_rd_pend <= mem_re;
                    if (keep) begin
                        r_wr_idx <= r_wr_idx + CW'(1);
                    end
                end else if (r_state == ST_READ) begin
                    r_rd_pend <= mem_re || (r_rd_pend && !move);
                end
            end

            if (move || empty_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // event latch, read position tag and output word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_chan <= i_event.midi_channel;
            r_note <= i_event.note_number;
            r_ovf  <= is_on && !room;
        end
        if (mem_re) begin
            r_q_pos <= r_rd_idx;
        end
        if (move || empty_load) begin
            r_out.frames_elapsed <= r_delta;
            r_out.table_count    <= hnt_pkg::TCOUNT_W'(r_count);
            r_out.overflow       <= r_ovf;
            r_out.entry_valid    <= move;
            r_out.entry_position <= move ? hnt_pkg::POS_W'(r_q_pos) : '0;
            r_out.entry_channel  <= move ? r_ram_q.chan : '0;
            r_out.entry_note     <= move ? r_ram_q.note : '0;
            r_out.entry_velocity <= move ? r_ram_q.vel : '0;
            r_out.last           <= empty_load || ((r_q_pos + CW'(1)) == r_count);
        end
    end

    // frame tracker: product, x441 scale, digit-serial divide by five, delta
    assign prod_c   = {{hnt_pkg::TICK_W{1'b0}}, r_period} *
                      {{hnt_pkg::PERIOD_W{1'b0}}, i_event.tick_count};
    assign scaled_c = {{hnt_pkg::MUL_W{1'b0}}, r_fr_prod} *
                      hnt_pkg::SCALED_W'(hnt_pkg::SAMPLE_MUL);
    assign dstep    = hnt_pkg::div5_step(r_div_rem,
                          r_div_num[hnt_pkg::NUM_W-1 -: hnt_pkg::DIGIT_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr_state <= FR_IDLE;
            r_last_pos <= '0;
        end else begin
            unique case (r_fr_state)
                FR_IDLE: begin
                    if (accept) begin
                        r_fr_state <= FR_SCALE;
                    end
                end
                FR_SCALE: r_fr_state <= FR_DIV;
                FR_DIV: begin
                    if (r_div_cnt == '0) begin
                        r_fr_state <= FR_DELTA;
                    end
                end
                FR_DELTA: begin
                    r_last_pos <= r_div_quo;
                    r_fr_state <= FR_IDLE;
                end
                default: r_fr_state <= FR_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fr_prod <= prod_c;
        end
        if (r_fr_state == FR_SCALE) begin
            r_div_num <= scaled_c[hnt_pkg::SCALED_W-1 -: hnt_pkg::NUM_W];
            r_div_rem <= '0;
            r_div_quo <= '0;
            r_div_cnt <= hnt_pkg::DCNT_W'(hnt_pkg::DIV_DIGITS - 1);
        end
        if (r_fr_state == FR_DIV) begin
            r_div_num <= r_div_num << hnt_pkg::DIGIT_W;
            r_div_rem <= dstep.rem;
            r_div_quo <= {r_div_quo[hnt_pkg::FRAME_W-hnt_pkg::DIGIT_W-1:0], dstep.quo};
            r_div_cnt <= r_div_cnt - hnt_pkg::DCNT_W'(1);
        end
        if (r_fr_state == FR_DELTA) begin
            r_delta <= r_div_quo - r_last_pos;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.frames_elapsed = r_out.frames_elapsed;
    assign o_result.entry_valid    = r_out.entry_valid;
    assign o_result.entry_position = r_out.entry_position;
    assign o_result.entry_channel  = r_out.entry_channel;
    assign o_result.entry_note     = r_out.entry_note;
    assign o_result.entry_velocity = r_out.entry_velocity;
    assign o_result.table_count    = r_out.table_count;
    assign o_result.overflow       = r_out.overflow;
    assign o_result.last           = r_out.last;

endmodule

`default_nettype wire

### rtl/core/hnt_checker.sv
// Port-level checks on the result channel of the held note table, bound to held_note_table_core.
`default_nettype none
`include "held_note_table_core_macros.svh"

module hnt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          i_ready,
    input wire logic                          i_last,
    input wire logic                          i_entry_valid,
    input wire logic [hnt_pkg::POS_W-1:0]     i_entry_position,
    input wire logic [hnt_pkg::TCOUNT_W-1:0]  i_table_count,
    input wire logic                          i_overflow,
    input wire logic [hnt_pkg::FRAME_W-1:0]   i_frames
);

    `HNT_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, i_valid && !i_ready, i_valid)
    `HNT_ASSERT_NEXT(a_hold_word, i_clk, i_rst_n, i_valid && !i_ready, $stable(i_last) && $stable(i_entry_position) && $stable(i_frames))
    `HNT_ASSERT_IMPL(a_empty_word, i_clk, i_rst_n, i_valid && !i_entry_valid, i_last && (i_table_count == '0))
    `HNT_ASSERT_IMPL(a_entry_pos, i_clk, i_rst_n, i_valid && i_entry_valid, (i_last == ((hnt_pkg::TCOUNT_W'(i_entry_position) + 6'd1) == i_table_count)) && (hnt_pkg::TCOUNT_W'(i_entry_position) < i_table_count))
    `HNT_ASSERT_IMPL(a_overflow_full, i_clk, i_rst_n, i_valid && i_overflow, i_table_count == hnt_pkg::TCOUNT_W'(hnt_pkg::TABLE_DEPTH))

endmodule

bind held_note_table_core hnt_checker u_hnt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_result.valid),
    .i_ready          (o_result.ready),
    .i_last           (o_result.last),
    .i_entry_valid    (o_result.entry_valid),
    .i_entry_position (o_result.entry_position),
    .i_table_count    (o_result.table_count),
    .i_overflow       (o_result.overflow),
    .i_frames         (o_result.frames_elapsed)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for held_note_table_core: directed table, then random note traffic.

module tb_top;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          DRAIN_CYCLES  = 100;
    localparam int          MAX_REPORTS   = 10;
    localparam int          PHASE_COUNT   = 6;
    localparam int          PHASE_ITEMS   = 73;
    localparam logic [1:0]  ACT_RESERVED  = 2'd3;  // unused code, behaves like "other"

    // Typed-in words for rows whose outcome is obvious.
    localparam hnt_pkg::t_result W_EMPTY_NO_MOVE = '{frames_elapsed: '0, entry_valid: 1'b0,
        entry_position: '0, entry_channel: '0, entry_note: '0, entry_velocity: '0,
        table_count: '0, overflow: 1'b0, last: 1'b1};
    localparam hnt_pkg::t_result W_ONE_ZERO_NOTE = '{frames_elapsed: '0, entry_valid: 1'b1,
        entry_position: '0, entry_channel: '0, entry_note: '0, entry_velocity: '0,
        table_count: 6'd1, overflow: 1'b0, last: 1'b1};

    typedef struct {
        logic [1:0]       act;
        logic [3:0]       ch;
        logic [6:0]       nt;
        logic [6:0]       vel;
        logic [31:0]      ticks;
        bit               typed;   // word below replaces the predicted single word
        hnt_pkg::t_result word;
    } t_stim_row;

    // Directed table: extremes, each action, duplicates, misses, wrap of the delta.
    localparam int DIRECTED_ROWS = 21;
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{hnt_pkg::ACT_OTHER,    4'd0,  7'd0,   7'd0,   32'd0,         1'b1, W_EMPTY_NO_MOVE},
        '{hnt_pkg::ACT_NOTE_OFF, 4'd15, 7'd127, 7'd127, 32'd0,         1'b1, W_EMPTY_NO_MOVE},
        '{hnt_pkg::ACT_NOTE_ON,  4'd0,  7'd0,   7'd0,   32'd0,         1'b1, W_ONE_ZERO_NOTE},
        '{hnt_pkg::ACT_NOTE_ON,  4'd15, 7'd127, 7'd127, 32'd1,         1'b0, '0},
        '{hnt_pkg::ACT_NOTE_ON,  4'd15, 7'd127, 7'd1,   32'd2,         1'b0, '0},
        '{hnt_pkg::ACT_NOTE_ON,  4'd3,  7'd127, 7'd64,  32'd3,         1'b0, '0},
        '{hnt_pkg::ACT_NOTE_ON,  4'd15, 7'd5,   7'd64,  32'd100,       1'b0, '0},
        '{ACT_RESERVED,          4'd15, 7'd5,   7'd64,  32'd1000,      1'b0, '0},
        '{hnt_pkg::ACT_NOTE_OFF, 4'd15, 7'd127, 7'd0,   32'd2000,      1'b0, '0},
        '{hnt_pkg::ACT_NOTE_OFF, 4'd9,  7'd9,   7'd9,   32'd2000,      1'b0, '0},
        '{hnt_pkg::ACT_OTHER,    4'd0,  7'd0,   7'd0,   32'hFFFF_FFFF, 1'b0, '0},
        '{hnt_pkg::ACT_OTHER,    4'd15, 7'd127, 7'd127, 32'd0,         1'b0, '0},
        '{hnt_pkg::ACT_NOTE_OFF, 4'd0,  7'd0,   7'd0,   32'd7,         1'b0, '0},
        '{hnt_pkg::ACT_NOTE_OFF, 4'd3,  7'd127, 7'd0,   32'd8,         1'b0, '0},
        '{hnt_pkg::ACT_NOTE_OFF, 4'd15, 7'd5,   7'd0,   32'd9,         1'b0, '0},
        '{hnt_pkg::ACT_NOTE_ON,  4'd10, 7'd60,  7'd100, 32'h8000_0000, 1'b0, '0},
        '{hnt_pkg::ACT_NOTE_ON,  4'd5,  7'h55,  7'h2A,  32'h5555_5555, 1'b0, '0},
        '{hnt_pkg::ACT_NOTE_ON,  4'd10, 7'h2A,  7'h55,  32'hAAAA_AAAA, 1'b0, '0},
        '{hnt_pkg::ACT_NOTE_OFF, 4'd10, 7'd60,  7'd0,   32'hAAAA_AAAA, 1'b0, '0},
        '{hnt_pkg::ACT_NOTE_OFF, 4'd5,  7'h55,  7'd0,   32'hFFFF_0000, 1'b0, '0},
        '{hnt_pkg::ACT_NOTE_OFF, 4'd10, 7'h2A,  7'd0,   32'h0000_FFFF, 1'b0, '0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [hnt_pkg::PERIOD_W-1:0] cfg_wr_data = '0;
    logic sink_ready = 1'b0;

    hnt_event_if  event_bus ();
    hnt_result_if result_bus ();

    assign result_bus.ready = sink_ready;

    held_note_table_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_event       (event_bus),
        .o_result      (result_bus)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predicted copy of the block state
    // ---------------------------------------------------------------
    hnt_pkg::t_entry              held_notes [hnt_pkg::TABLE_DEPTH];
    int                           held_count   = 0;
    logic [hnt_pkg::FRAME_W-1:0]  frame_pos    = '0;
    logic [hnt_pkg::PERIOD_W-1:0] tick_period  = hnt_pkg::PERIOD_RESET;

    hnt_pkg::t_result expected_words [$];

    int  fail_count   = 0;
    int  words_seen   = 0;
    int  items_sent   = 0;
    int  cycle_count  = 0;
    int  stall_left   = 0;
    bit  idle_on      = 1'b1;
    logic [31:0] track_ticks = '0;

    // Exact floor(period * ticks * 441 / 655360); 64b product times 441 needs 73 bits.
    function automatic logic [hnt_pkg::FRAME_W-1:0] ticks_to_frames(
        input logic [31:0] period, input logic [31:0] ticks);
        logic [72:0] scaled;
        scaled = {41'd0, period} * {41'd0, ticks};
        scaled = scaled * 73'd441;
        return hnt_pkg::FRAME_W'(scaled / 73'd655360);
    endfunction

    // Apply one accepted event to the predicted table and queue its words.
    function automatic int advance_note_table(input logic [1:0] act, input logic [3:0] ch,
                                              input logic [6:0] nt, input logic [6:0] vel,
                                              input logic [31:0] ticks);
        logic [hnt_pkg::FRAME_W-1:0] new_pos;
        logic [hnt_pkg::FRAME_W-1:0] delta;
        logic                        ovf;
        int                          keep;
        int                          n;
        hnt_pkg::t_result            w;
        new_pos   = ticks_to_frames(tick_period, ticks);
        delta     = new_pos - frame_pos;
        frame_pos = new_pos;
        ovf       = 1'b0;
        if (act == hnt_pkg::ACT_NOTE_ON) begin
            if (held_count < hnt_pkg::TABLE_DEPTH) begin
                held_notes[held_count] = '{chan: ch, note: nt, vel: vel};
                held_count++;
            end else begin
                ovf = 1'b1;
            end
        end else if (act == hnt_pkg::ACT_NOTE_OFF) begin
            // drop every match, survivors slide down in order
            keep = 0;
            for (int i = 0; i < held_count; i++) begin
                if (!(held_notes[i].note == nt && held_notes[i].chan == ch)) begin
                    held_notes[keep] = held_notes[i];
                    keep++;
                end
            end
            held_count = keep;
        end
        n = (held_count != 0) ? held_count : 1;
        for (int i = 0; i < n; i++) begin
            w                = '0;
            w.frames_elapsed = delta;
            w.table_count    = hnt_pkg::TCOUNT_W'(held_count);
            w.overflow       = ovf;
            w.last           = (i == n - 1);
            if (held_count != 0) begin
                w.entry_valid    = 1'b1;
                w.entry_position = hnt_pkg::POS_W'(i);
                w.entry_channel  = held_notes[i].chan;
                w.entry_note     = held_notes[i].note;
                w.entry_velocity = held_notes[i].vel;
            end
            expected_words.push_back(w);
        end
        return n;
    endfunction

    // ---------------------------------------------------------------
    // Event sender: drives at the falling edge, sees acceptance at the rising one
    // ---------------------------------------------------------------
    task automatic send_item(input logic [1:0] act, input logic [3:0] ch,
                             input logic [6:0] nt, input logic [6:0] vel,
                             input logic [31:0] ticks, output int n_words);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            event_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        event_bus.valid         <= 1'b1;
        event_bus.action        <= act;
        event_bus.midi_channel  <= ch;
        event_bus.note_number   <= nt;
        event_bus.note_velocity <= vel;
        event_bus.tick_count    <= ticks;
        @(posedge i_clk);
        while (!event_bus.ready) @(posedge i_clk);
        n_words = advance_note_table(act, ch, nt, vel, ticks);
        items_sent++;
    endtask

    // Lower valid and hold off until every predicted word came back.
    task automatic wait_drained();
        @(negedge i_clk);
        event_bus.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_tick_period(input logic [31:0] value);
        wait_drained();
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        tick_period  = value;
    endtask

    // Mostly a small pitch pool so duplicates and note-off hits are common.
    task automatic pick_pitch(output logic [3:0] ch, output logic [6:0] nt);
        if ($urandom_range(0, 1) == 0) begin
            ch = 4'($urandom_range(0, 3));
            nt = 7'(60 + $urandom_range(0, 3));
        end else begin
            ch = 4'($urandom);
            nt = 7'($urandom);
        end
    endtask

    // Track position mostly creeps forward, sometimes jumps or hits the ends.
    function automatic logic [31:0] next_ticks();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)      track_ticks = track_ticks + 32'($urandom_range(0, 3000));
        else if (r < 85) track_ticks = $urandom;
        else if (r < 96 && r >= 92) track_ticks = '0;
        else if (r >= 96) track_ticks = '1;
        return track_ticks;
    endfunction

    task automatic random_event();
        int          r;
        int          idx;
        int          n;
        logic [1:0]  act;
        logic [3:0]  ch;
        logic [6:0]  nt;
        r = $urandom_range(0, 99);
        if (r < 45)      act = hnt_pkg::ACT_NOTE_ON;
        else if (r < 80) act = hnt_pkg::ACT_NOTE_OFF;
        else if (r < 95) act = hnt_pkg::ACT_OTHER;
        else             act = ACT_RESERVED;
        pick_pitch(ch, nt);
        if (act == hnt_pkg::ACT_NOTE_OFF && held_count != 0 && $urandom_range(0, 9) < 6)
        begin
            idx = $urandom_range(0, held_count - 1);
            ch  = held_notes[idx].chan;
            nt  = held_notes[idx].note;
        end
        send_item(act, ch, nt, 7'($urandom), next_ticks(), n);
    endtask

    // Fill the table, push it past full, then release notes until few remain.
    task automatic fill_and_release();
        int          idx;
        int          n;
        logic [3:0]  ch;
        logic [6:0]  nt;
        while (held_count < hnt_pkg::TABLE_DEPTH) begin
            pick_pitch(ch, nt);
            send_item(hnt_pkg::ACT_NOTE_ON, ch, nt, 7'($urandom), next_ticks(), n);
        end
        repeat (2) begin
            pick_pitch(ch, nt);
            send_item(hnt_pkg::ACT_NOTE_ON, ch, nt, 7'($urandom), next_ticks(), n);
        end
        while (held_count > 4) begin
            idx = $urandom_range(0, held_count - 1);
            send_item(hnt_pkg::ACT_NOTE_OFF, held_notes[idx].chan, held_notes[idx].note,
                      7'($urandom), next_ticks(), n);
        end
    endtask

    // ---------------------------------------------------------------
    // Result receiver: random stall bursts while idling is on
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            sink_ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            sink_ready <= 1'b0;
            stall_left  = $urandom_range(0, 3);
        end else begin
            sink_ready <= 1'b1;
        end
    end

    // Word checker: every accepted word against the oldest prediction.
    always @(posedge i_clk) begin
        hnt_pkg::t_result want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            words_seen++;
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected word %0d at cycle %0d", words_seen, cycle_count);
            end else begin
                want = expected_words.pop_front();
                if (result_bus.frames_elapsed !== want.frames_elapsed ||
                    result_bus.entry_valid    !== want.entry_valid    ||
                    result_bus.entry_position !== want.entry_position ||
                    result_bus.entry_channel  !== want.entry_channel  ||
                    result_bus.entry_note     !== want.entry_note     ||
                    result_bus.entry_velocity !== want.entry_velocity ||
                    result_bus.table_count    !== want.table_count    ||
                    result_bus.overflow       !== want.overflow       ||
                    result_bus.last           !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display({"mismatch word %0d exp: d=%0d v=%0b p=%0d c=%0d",
                                  " n=%0d vel=%0d cnt=%0d o=%0b l=%0b"},
                                 words_seen, want.frames_elapsed, want.entry_valid,
                                 want.entry_position, want.entry_channel, want.entry_note,
                                 want.entry_velocity, want.table_count, want.overflow,
                                 want.last);
                        $display({"mismatch word %0d got: d=%0d v=%0b p=%0d c=%0d",
                                  " n=%0d vel=%0d cnt=%0d o=%0b l=%0b"},
                                 words_seen, result_bus.frames_elapsed,
                                 result_bus.entry_valid, result_bus.entry_position,
                                 result_bus.entry_channel, result_bus.entry_note,
                                 result_bus.entry_velocity, result_bus.table_count,
                                 result_bus.overflow, result_bus.last);
                    end
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int          n;
        int          target;
        logic [31:0] period;
        event_bus.valid         = 1'b0;
        event_bus.action        = '0;
        event_bus.midi_channel  = '0;
        event_bus.note_number   = '0;
        event_bus.note_velocity = '0;
        event_bus.tick_count    = '0;

        // hold reset, then release it at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows run at the reset period
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_item(directed_rows[i].act, directed_rows[i].ch, directed_rows[i].nt,
                      directed_rows[i].vel, directed_rows[i].ticks, n);
            if (directed_rows[i].typed && n == 1)
                expected_words[expected_words.size() - 1] = directed_rows[i].word;
        end
        track_ticks = '0;

        // random phases, each under its own tick period
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0:       period = 32'd65536;       // exactly 1 ms per tick
                1:       period = '0;
                2:       period = '1;
                3:       period = $urandom;
                4:       period = hnt_pkg::PERIOD_RESET;
                default: period = 32'($urandom_range(1, 200000));
            endcase
            set_tick_period(period);
            if (ph == PHASE_COUNT - 1) idle_on = 1'b0;   // closing stretch runs flat out
            target = items_sent + PHASE_ITEMS;
            if (ph == 0 || ph == 3) fill_and_release();
            while (items_sent < target) begin
                random_event();
                // sender holds off once mid-phase until the block has emptied out
                if (ph == 1 && items_sent == target - PHASE_ITEMS / 2)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
